// ===== sv/top_k_latest_arrival_list_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TOP_K_LATEST_ARRIVAL_LIST_UNIT_ASSERT_SVH
`define TOP_K_LATEST_ARRIVAL_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TKL_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TKL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tkl_pkg.sv =====
// ----------------------------------------------------------------------------
// tkl_pkg
// Shared widths, slot and control types for the latest-arrival list.
// ----------------------------------------------------------------------------
package tkl_pkg;

    localparam int LIST_SIZE = 8;
    localparam int IDX_W     = 16;
    localparam int ARR_W     = 32;
    localparam int LIMIT_W   = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        index;
        logic signed [ARR_W-1:0] arrival;
    } slot_t;

    typedef struct packed {
        logic step;    // entry beat accepted: insert
        logic pop;     // rank beat accepted: shift toward cell 0
        logic active;  // cell lies below the list limit
    } cell_ctrl_t;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } state_t;

endpackage

// ===== sv/tkl_in_if.sv =====
// ----------------------------------------------------------------------------
// tkl_in_if
// Entry channel: output number, arrival time and end-of-stream mark.
// ----------------------------------------------------------------------------
interface tkl_in_if;
    logic                             valid;
    logic                             ready;
    logic [tkl_pkg::IDX_W-1:0]        out_index;
    logic signed [tkl_pkg::ARR_W-1:0] arrival;
    logic                             last_item;

    modport source (output valid, output out_index, output arrival, output last_item,
                    input ready);
    modport sink   (input valid, input out_index, input arrival, input last_item,
                    output ready);
endinterface

// ===== sv/tkl_out_if.sv =====
// ----------------------------------------------------------------------------
// tkl_out_if
// Rank channel: one kept entry per beat, latest first.
// ----------------------------------------------------------------------------
interface tkl_out_if;
    logic                             valid;
    logic                             ready;
    logic [tkl_pkg::IDX_W-1:0]        rank_index;
    logic signed [tkl_pkg::ARR_W-1:0] rank_arrival;
    logic                             last_result;

    modport source (output valid, output rank_index, output rank_arrival,
                    output last_result, input ready);
    modport sink   (input valid, input rank_index, input rank_arrival,
                    input last_result, output ready);
endinterface

// ===== sv/tkl_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tkl_cfg_if
// Configuration write channel for the list limit.
// ----------------------------------------------------------------------------
interface tkl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tkl_pkg::LIMIT_W-1:0]   list_limit;

    modport source (output valid, output list_limit, input ready);
    modport sink   (input valid, input list_limit, output ready);
endinterface

// ===== sv/tkl_cell.sv =====
// ----------------------------------------------------------------------------
// tkl_cell
// One list slot: compare against the incoming arrival, then hold, load the new
// entry, take the upper neighbor's slot, clear if inactive, or take the lower on a pop.
// ----------------------------------------------------------------------------
module tkl_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tkl_pkg::cell_ctrl_t              ctrl,
    input  logic [tkl_pkg::IDX_W-1:0]        new_index,
    input  logic signed [tkl_pkg::ARR_W-1:0] new_arrival,
    input  tkl_pkg::slot_t                   prev_slot,
    input  logic                             prev_take,
    input  tkl_pkg::slot_t                   next_slot,
    output tkl_pkg::slot_t                   slot,
    output logic                             take
);

    logic                             valid_reg, valid_next;
    logic [tkl_pkg::IDX_W-1:0]        index_reg, index_next;
    logic signed [tkl_pkg::ARR_W-1:0] arrival_reg, arrival_next;

    // Entry goes at or above this slot unless the slot holds an equal or later arrival.
    assign take = !(valid_reg && ctrl.active && (arrival_reg >= new_arrival));

    always_comb
    begin
        valid_next   = valid_reg;
        index_next   = index_reg;
        arrival_next = arrival_reg;
        if (ctrl.step)
        begin
            if (!ctrl.active)
            begin
                valid_next = 1'b0;
            end
            else if (take && !prev_take)
            begin
                valid_next   = 1'b1;
                index_next   = new_index;
                arrival_next = new_arrival;
            end
            else if (take)
            begin
                valid_next   = prev_slot.valid;
                index_next   = prev_slot.index;
                arrival_next = prev_slot.arrival;
            end
        end
        else if (ctrl.pop)
        begin
            valid_next   = next_slot.valid;
            index_next   = next_slot.index;
            arrival_next = next_slot.arrival;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg   <= index_next;
        arrival_reg <= arrival_next;
    end

    assign slot = '{valid: valid_reg, index: index_reg, arrival: arrival_reg};

endmodule

// ===== sv/top_k_latest_arrival_list_unit.sv =====
// ----------------------------------------------------------------------------
// top_k_latest_arrival_list_unit
// Keeps the latest-arriving entries of a stream, sorted, and reports them.
// ----------------------------------------------------------------------------
// The list lives in a row of LIST_SIZE cells, cell 0 holding the latest
// arrival. While collecting, one entry beat is taken every cycle: all cells
// compare the new arrival with their own in parallel, the first cell whose
// slot is empty or earlier loads the entry, cells below it take their upper
// neighbor's slot, and the last kept entry falls off a full list. Ties keep
// the older entry ahead. An entry whose place is at or past list_limit is
// dropped. A limit of 0 acts as 1, any above LIST_SIZE as LIST_SIZE; a
// lowered limit cuts the list at the next entry. On an entry with last_item
// set, the list then drains through cell 0, one rank beat per cycle for each
// kept entry (from 1 beat up to the effective limit, stretched by any rank
// stall), with last_result on the final beat; entry ready stays low while
// draining and the list is empty afterward. The configuration channel is
// always ready and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module top_k_latest_arrival_list_unit (
    input  logic         clk,
    input  logic         rst_n,
    tkl_cfg_if.sink      cfg,
    tkl_in_if.sink       entry,
    tkl_out_if.source    rank
);

    localparam int N = tkl_pkg::LIST_SIZE;

    tkl_pkg::state_t state_reg, state_next;
    logic [tkl_pkg::LIMIT_W-1:0] limit_reg;

    logic step;
    logic pop;

    tkl_pkg::slot_t slots [N];
    logic           takes [N];

    // Configuration: take every write beat.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tkl_pkg::LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            limit_reg <= cfg.list_limit;
        end
    end

    // Handshakes: entries only while collecting, ranks only while draining.
    assign step = entry.valid && entry.ready;
    assign pop  = rank.valid && rank.ready;

    // Mode control.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tkl_pkg::ST_COLLECT:
            begin
                if (step && entry.last_item)
                begin
                    state_next = tkl_pkg::ST_EMIT;
                end
            end
            tkl_pkg::ST_EMIT:
            begin
                if (pop && rank.last_result)
                begin
                    state_next = tkl_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = tkl_pkg::ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tkl_pkg::ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        entry.ready = 1'b0;
        rank.valid  = 1'b0;
        unique case (state_reg)
            tkl_pkg::ST_COLLECT: entry.ready = 1'b1;
            tkl_pkg::ST_EMIT:    rank.valid  = 1'b1;
            default:             entry.ready = 1'b0;
        endcase
    end

    // Cell row.
    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            tkl_pkg::cell_ctrl_t ctrl;
            tkl_pkg::slot_t      prev_slot;
            tkl_pkg::slot_t      next_slot;
            logic                prev_take;

            // Limit 0 keeps only cell 0 active.
            assign ctrl.step   = step;
            assign ctrl.pop    = pop;
            assign ctrl.active = (limit_reg == '0) ? (i == 0)
                                                   : (32'(limit_reg) > 32'(i));

            if (i == 0)
            begin : g_head
                assign prev_slot = '0;
                assign prev_take = 1'b0;
            end
            else
            begin : g_body
                assign prev_slot = slots[i-1];
                assign prev_take = takes[i-1];
            end

            if (i == N - 1)
            begin : g_tail
                assign next_slot = '0;
            end
            else
            begin : g_link
                assign next_slot = slots[i+1];
            end

            tkl_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_index   (entry.out_index),
                .new_arrival (entry.arrival),
                .prev_slot   (prev_slot),
                .prev_take   (prev_take),
                .next_slot   (next_slot),
                .slot        (slots[i]),
                .take        (takes[i])
            );
        end
    endgenerate

    // Cell 0 is the head of the list; the beat is last when cell 1 is empty.
    assign rank.rank_index   = slots[0].index;
    assign rank.rank_arrival = slots[0].arrival;

    generate
        if (N > 1)
        begin : g_last_multi
            assign rank.last_result = !slots[1].valid;
        end
        else
        begin : g_last_single
            assign rank.last_result = 1'b1;
        end
    endgenerate

endmodule

// ===== sv/tkl_checker.sv =====
// ----------------------------------------------------------------------------
// tkl_checker
// Port-level checks on the latest-arrival list, bound to the top level.
// ----------------------------------------------------------------------------
`include "top_k_latest_arrival_list_unit_assert.svh"

module tkl_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             entry_valid,
    input logic                             entry_ready,
    input logic                             entry_last_item,
    input logic                             rank_valid,
    input logic                             rank_ready,
    input logic [tkl_pkg::IDX_W-1:0]        rank_index,
    input logic signed [tkl_pkg::ARR_W-1:0] rank_arrival,
    input logic                             rank_last_result
);

    `TKL_ASSERT_NEXT(a_rank_hold, rank_valid && !rank_ready,
        rank_valid && $stable(rank_index) && $stable(rank_arrival)
        && $stable(rank_last_result), "rank beat changed while stalled")

    `TKL_ASSERT_NOW(a_no_entry_while_draining, rank_valid, !entry_ready,
        "entry taken while the list drains")

    `TKL_ASSERT_NEXT(a_drain_after_last, entry_valid && entry_ready && entry_last_item,
        rank_valid, "no drain after the last entry")

    `TKL_ASSERT_NEXT(a_drain_ends, rank_valid && rank_ready && rank_last_result,
        !rank_valid && entry_ready, "drain did not end after its last beat")

endmodule

bind top_k_latest_arrival_list_unit tkl_checker u_tkl_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .entry_valid      (entry.valid),
    .entry_ready      (entry.ready),
    .entry_last_item  (entry.last_item),
    .rank_valid       (rank.valid),
    .rank_ready       (rank.ready),
    .rank_index       (rank.rank_index),
    .rank_arrival     (rank.rank_arrival),
    .rank_last_result (rank.last_result)
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the top-k latest-arrival list unit.
// ----------------------------------------------------------------------------
// Entry beats stream into the unit from a queue of pending entries. Each
// accepted beat runs through a sorted-list predictor that keeps its own copy
// of the list and the limit. On a beat marked last, the predictor queues the
// ranks it expects the unit to emit. A monitor checks every rank beat
// against the oldest queued rank. The run has a short directed part, then
// random phases. Each phase writes a new limit while the unit is quiet.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_SIZE = tkl_pkg::LIST_SIZE;
    localparam int IDX_W     = tkl_pkg::IDX_W;
    localparam int ARR_W     = tkl_pkg::ARR_W;
    localparam int LIMIT_W   = tkl_pkg::LIMIT_W;

    // Watchdog limit in clock cycles. The slowest correct run is far below this.
    localparam int CYCLE_LIMIT = 200000;
    // Receiver hold-off that backs the unit up into its entry port.
    localparam int LONG_STALL  = 150;

    typedef struct {
        logic [IDX_W-1:0]        index;
        logic signed [ARR_W-1:0] arrival;
        logic                    last_item;
    } entry_t;

    typedef struct {
        logic [IDX_W-1:0]        index;
        logic signed [ARR_W-1:0] arrival;
        logic                    last_result;
    } rank_t;

    logic clk;
    logic rst_n;

    tkl_cfg_if cfg_ch ();
    tkl_in_if  entry_ch ();
    tkl_out_if rank_ch ();

    top_k_latest_arrival_list_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .entry (entry_ch),
        .rank  (rank_ch)
    );

    // Predictor state: the sorted list as the unit should hold it.
    logic [IDX_W-1:0]        list_index   [LIST_SIZE];
    logic signed [ARR_W-1:0] list_arrival [LIST_SIZE];
    int                      list_count;
    logic [LIMIT_W-1:0]      limit_shadow;

    entry_t entry_pending [$];  // entries waiting for the driver
    rank_t  ranks_due     [$];  // ranks the unit still owes us
    entry_t next_beat;

    int  queued_n;      // entries pushed to the pending queue
    int  accepted_n;    // entry beats taken by the unit
    int  err_n;
    int  cycle_n;
    int  send_gap;      // driver idle cycles left
    int  stall_left;    // monitor hold-off cycles left
    int  long_req;      // bumped by the sequencer to ask for a long hold-off
    int  long_seen;
    bit  idle_on;       // random idling on both sides

    // Clock: 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: end the run if the unit hangs.
    always @(posedge clk)
    begin
        cycle_n++;
        if (cycle_n == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d ranks still due", $time, ranks_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Insert one accepted entry into the predicted list. On a beat marked
    // last, queue the whole list as expected ranks and empty it.
    function automatic void insert_arrival(logic [IDX_W-1:0] index,
                                           logic signed [ARR_W-1:0] arrival,
                                           logic last_item);
        int    lim;
        int    pos;
        rank_t due;
        // A limit of 0 acts as 1, anything past the list size as the list size.
        lim = int'(limit_shadow);
        if (lim < 1)
            lim = 1;
        if (lim > LIST_SIZE)
            lim = LIST_SIZE;
        // A limit lowered since the last beat cuts the list here.
        if (list_count > lim)
            list_count = lim;
        // Go past every kept entry that arrived at the same time or later,
        // so older entries win ties.
        pos = 0;
        while (pos < list_count && list_arrival[pos] >= arrival)
            pos++;
        if (pos < lim)
        begin
            if (list_count < lim)
                list_count++;
            for (int v = list_count - 1; v > pos; v--)
            begin
                list_index[v]   = list_index[v - 1];
                list_arrival[v] = list_arrival[v - 1];
            end
            list_index[pos]   = index;
            list_arrival[pos] = arrival;
        end
        if (last_item)
        begin
            for (int r = 0; r < list_count; r++)
            begin
                due.index       = list_index[r];
                due.arrival     = list_arrival[r];
                due.last_result = (r == list_count - 1);
                ranks_due.push_back(due);
            end
            list_count = 0;
        end
    endfunction

    // Entry driver: hold the beat until it is taken, then offer the next
    // pending entry, with random idle bursts between beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_ch.valid     <= 1'b0;
            entry_ch.out_index <= '0;
            entry_ch.arrival   <= '0;
            entry_ch.last_item <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (entry_ch.valid && entry_ch.ready)
            begin
                insert_arrival(entry_ch.out_index, entry_ch.arrival, entry_ch.last_item);
                accepted_n++;
            end
            if (!entry_ch.valid || entry_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    entry_ch.valid <= 1'b0;
                end
                else if (entry_pending.size() > 0)
                begin
                    next_beat = entry_pending.pop_front();
                    entry_ch.valid     <= 1'b1;
                    entry_ch.out_index <= next_beat.index;
                    entry_ch.arrival   <= next_beat.arrival;
                    entry_ch.last_item <= next_beat.last_item;
                    if (idle_on && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 16);
                end
                else
                begin
                    entry_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Compare one rank field; report and count a mismatch.
    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            err_n++;
            $display("%0t: rank %s mismatch: expected %h actual %h", $time, field, want, got);
        end
    endtask

    // Rank monitor: check each rank beat against the oldest due rank and
    // stall the rank port in random bursts, or for one long stretch on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rank_ch.valid && rank_ch.ready)
            begin
                if (ranks_due.size() == 0)
                begin
                    err_n++;
                    $display("%0t: unexpected rank beat: expected none actual index %h arrival %h",
                             $time, rank_ch.rank_index, rank_ch.rank_arrival);
                end
                else
                begin
                    check_field("index", 32'(ranks_due[0].index), 32'(rank_ch.rank_index));
                    check_field("arrival", 32'(ranks_due[0].arrival),
                                32'(rank_ch.rank_arrival));
                    check_field("last_result", 32'(ranks_due[0].last_result),
                                32'(rank_ch.last_result));
                    void'(ranks_due.pop_front());
                end
            end
            if (long_req != long_seen)
            begin
                long_seen  = long_req;
                stall_left = LONG_STALL;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rank_ch.ready <= 1'b0;
            end
            else
            begin
                rank_ch.ready <= 1'b1;
            end
        end
    end

    // Queue one entry for the driver.
    task automatic push_entry(logic [IDX_W-1:0] index, logic signed [ARR_W-1:0] arrival,
                              logic last_item);
        entry_t e;
        e.index     = index;
        e.arrival   = arrival;
        e.last_item = last_item;
        entry_pending.push_back(e);
        queued_n++;
    endtask

    // Pick an arrival: half narrow values so ties and reordering are common,
    // a third full-range values and the rest extremes.
    function automatic logic signed [ARR_W-1:0] pick_arrival();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom();
            2:       return ARR_W'($urandom_range(0, 3)) << 16;
            3:       return -(ARR_W'($urandom_range(0, 3)) << 16);
            4:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return ARR_W'($urandom_range(0, 7)) - 32'sd4;
        endcase
    endfunction

    // Queue one stream of random entries; close it with a last mark or not.
    task automatic push_stream(int len, bit close);
        for (int i = 0; i < len; i++)
            push_entry(IDX_W'($urandom_range(0, 65535)), pick_arrival(),
                       close && (i == len - 1));
    endtask

    // Wait until every entry is taken and every due rank has come, then let
    // the last insert settle.
    task automatic wait_quiet(int settle);
        while (accepted_n != queued_n || ranks_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write the list limit; call only while quiet, the unit does not enforce it.
    task automatic write_limit(logic [LIMIT_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.list_limit <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        limit_shadow = value;
    endtask

    // Sequencer: reset, directed streams, then random phases.
    initial
    begin
        logic [LIMIT_W-1:0] limits [8];
        int                 n;
        int                 len;

        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.list_limit = tkl_pkg::LIMIT_RESET;
        limit_shadow      = tkl_pkg::LIMIT_RESET;
        list_count        = 0;
        idle_on           = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset limit: a one-entry stream at the top extremes.
        push_entry(16'hFFFF, 32'sh7FFF_FFFF, 1'b1);
        // Nine entries into eight slots: the earliest falls off. Includes
        // both arrival extremes, a tie with an older entry, and a closing
        // entry that is dropped from the full list.
        push_entry(16'h0001, 32'sh0000_0000, 1'b0);
        push_entry(16'h0002, 32'shFFFF_FFFF, 1'b0);
        push_entry(16'h0003, 32'sh8000_0000, 1'b0);
        push_entry(16'h0004, 32'sh7FFF_FFFF, 1'b0);
        push_entry(16'h0005, 32'sh0000_0000, 1'b0);
        push_entry(16'h0006, 32'sh0001_0000, 1'b0);
        push_entry(16'h0007, 32'sh0000_8000, 1'b0);
        push_entry(16'h0008, -32'sh0001_0000, 1'b0);
        push_entry(16'h0009, 32'sh0000_0001, 1'b0);
        push_entry(16'h0000, 32'sh8000_0000, 1'b1);
        wait_quiet(8);

        // Limit 0 acts as 1: a tie is dropped, a later arrival replaces.
        write_limit(4'd0);
        push_entry(16'hAAAA, 32'sh0000_0005, 1'b0);
        push_entry(16'h5555, 32'sh0000_0005, 1'b0);
        push_entry(16'h1234, 32'sh0000_0006, 1'b1);
        wait_quiet(8);

        // Fill three slots, then lower the limit to 1 with the list still
        // filled: the next beat cuts it to the latest entry.
        write_limit(4'd3);
        push_entry(16'h0101, 32'sh0003_0000, 1'b0);
        push_entry(16'h0202, 32'sh0001_0000, 1'b0);
        push_entry(16'h0303, 32'sh0002_0000, 1'b0);
        wait_quiet(8);
        write_limit(4'd1);
        push_entry(16'h0404, 32'sh0000_8000, 1'b1);

        // Random phases. Most streams close with a last mark; some stay open
        // across the next limit write.
        limits = '{4'd15, 4'd8, 4'd1, 4'd0, 4'd5, 4'd2, LIMIT_W'($urandom_range(0, 15)), 4'd8};
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_quiet(8);
            write_limit(limits[ph]);
            // Drop idling for one early phase and for the tail of the run.
            idle_on = (ph < 6) && (ph != 2);
            // Back up the rank port while short streams keep arriving.
            if (ph == 1)
                long_req++;
            n = 0;
            while (n < 8)
            begin
                len = (ph == 1) ? $urandom_range(1, 4) : $urandom_range(1, 10);
                push_stream(len, $urandom_range(0, 7) != 0);
                n += len;
            end
        end

        wait_quiet(20);
        if (err_n == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
